/* hw/rtl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define CLE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define CLE_NEVER(lbl, clk, rst_n, cond, msg) \
    `CLE_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

/* hw/rtl/cle_pkg.sv */
package cle_pkg;

    localparam int LINE_CAPACITY_DEF = 64;
    localparam int COUNT_W           = 6;

    localparam logic [7:0] CH_DEL        = 8'h7F;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_ETX        = 8'h03;
    localparam logic [7:0] CH_ESC        = 8'h1B;
    localparam logic [7:0] CH_LBRACKET   = 8'h5B;
    localparam logic [7:0] CSI_MIN       = 8'h20;
    localparam logic [7:0] CSI_MAX       = 8'h7E;
    localparam logic [7:0] CSI_FINAL_MIN = 8'h40;
    localparam logic [7:0] PRINT_MIN     = 8'd32;
    localparam logic [7:0] PRINT_MAX     = 8'd126;

    typedef enum logic [1:0] {
        K_ECHO  = 2'd0,
        K_ERASE = 2'd1,
        K_LINE  = 2'd2,
        K_ABORT = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] rx_byte;
    } t_rx;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         byte_value;
        logic               last;
        logic [COUNT_W-1:0] line_length;
    } t_res;

endpackage

/* hw/rtl/cle_stream_if.sv */
interface cle_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/console_line_editor_unit.sv */
// Console line editor. Takes one received byte per word on i_rx and returns
// echo, erase, abort and line-byte words on o_res. An ordinary byte is taken
// whenever the output register is empty or its word is taken in the
// same cycle; a result word left waiting in it holds off all input. A
// newline on a non-empty line replays the held bytes from the
// line store, each by a synchronous read of the store's read port, then
// a load of the output register once it is free; no input is
// taken during that replay. The store has LINE_CAPACITY entries and holds
// at most LINE_CAPACITY-1 bytes.
module console_line_editor_unit #(
    parameter int LINE_CAPACITY = cle_pkg::LINE_CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    cle_stream_if.sink          i_rx,
    cle_stream_if.source        o_res
);
    import cle_pkg::*;

    localparam int                 AW     = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
    localparam logic [COUNT_W-1:0] CAP_M1 = COUNT_W'(LINE_CAPACITY - 1);

    localparam logic [1:0] STEP_NONE = 2'd0;
    localparam logic [1:0] STEP_ESC  = 2'd1;
    localparam logic [1:0] STEP_CSI  = 2'd2;

    typedef enum logic [1:0] {
        S_RUN,
        S_READ,
        S_EMIT
    } t_state;

    logic [7:0] line_store [LINE_CAPACITY];
    logic [7:0] r_rd_data;

    t_state             r_state, n_state;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [1:0]         r_step, n_step;
    logic [COUNT_W-1:0] r_idx, n_idx;
    logic [COUNT_W-1:0] r_len, n_len;
    logic               r_out_valid, n_out_valid;
    t_res               r_out, n_out;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          slot_free;
    logic          accept;
    logic [7:0]    c;
    logic          normal;
    logic          is_last;

    assign slot_free   = !r_out_valid || o_res.ready;
    assign i_rx.ready  = (r_state == S_RUN) && slot_free;
    assign accept      = i_rx.valid && i_rx.ready;
    assign c           = i_rx.data.rx_byte;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;
    assign is_last     = (r_idx + COUNT_W'(1)) == r_len;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_idx       = r_idx;
        n_len       = r_len;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_addr     = r_count[AW-1:0];
        wr_data     = c;
        rd_en       = 1'b0;
        rd_addr     = r_idx[AW-1:0];
        normal      = 1'b0;

        unique case (r_state)
            S_RUN: begin
                if (accept) begin
                    priority if (c == CH_DEL) begin
                        if (r_count != '0) begin
                            n_count     = r_count - COUNT_W'(1);
                            n_out_valid = 1'b1;
                            n_out       = '{K_ERASE, 8'd0, 1'b0, '0};
                        end
                    end else if (c == CH_LF) begin
                        if (r_count != '0) begin
                            n_len   = r_count;
                            n_idx   = '0;
                            n_count = '0;
                            n_state = S_READ;
                        end
                    end else if (c == CH_ETX) begin
                        n_out_valid = 1'b1;
                        n_out       = '{K_ABORT, 8'd0, 1'b0, '0};
                    end else if (c == CH_ESC) begin
                        n_step = STEP_ESC;
                    end else begin
                        unique case (r_step)
                            STEP_ESC: begin
                                if (c == CH_LBRACKET) begin
                                    n_step = STEP_CSI;
                                end else begin
                                    n_step = STEP_NONE;
                                    normal = 1'b1;
                                end
                            end
                            STEP_CSI: begin
                                if (c >= CSI_MIN && c <= CSI_MAX) begin
                                    if (c >= CSI_FINAL_MIN) begin
                                        n_step = STEP_NONE;
                                    end
                                end else begin
                                    n_step = STEP_NONE;
                                    normal = 1'b1;
                                end
                            end
                            default: begin
                                n_step = STEP_NONE;
                                normal = 1'b1;
                            end
                        endcase
                        if (normal && c >= PRINT_MIN && c <= PRINT_MAX && r_count < CAP_M1) begin
                            wr_en       = 1'b1;
                            n_count     = r_count + COUNT_W'(1);
                            n_out_valid = 1'b1;
                            n_out       = '{K_ECHO, c, 1'b0, '0};
                        end
                    end
                end
            end
            S_READ: begin
                rd_en   = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{K_LINE, r_rd_data, is_last, r_len};
                    n_idx       = r_idx + COUNT_W'(1);
                    n_state     = is_last ? S_RUN : S_READ;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            line_store[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= line_store[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_count     <= '0;
            r_step      <= STEP_NONE;
            r_idx       <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_idx       <= n_idx;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

endmodule

/* hw/rtl/cle_checker.sv */
`include "assert_macros.svh"

module cle_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input cle_pkg::t_res               i_out_data
);
    import cle_pkg::*;

    // a stalled result word holds
    `CLE_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)), "stalled result word changed")

    // last and length belong to line words only
    `CLE_NEVER(a_last_kind, i_clk, i_rst_n, i_out_valid && i_out_data.kind != K_LINE && (i_out_data.last || i_out_data.line_length != '0), "last or length on a non-line word")

    // erase and abort carry no byte
    `CLE_NEVER(a_zero_byte, i_clk, i_rst_n, i_out_valid && (i_out_data.kind == K_ERASE || i_out_data.kind == K_ABORT) && i_out_data.byte_value != 8'd0, "byte on erase or abort word")

    // no input taken in the middle of a line run
    `CLE_NEVER(a_run_stall, i_clk, i_rst_n, i_in_ready && i_out_valid && i_out_data.kind == K_LINE && !i_out_data.last, "input ready during a line run")

    // a line word never claims an empty line
    `CLE_NEVER(a_line_len, i_clk, i_rst_n, i_out_valid && i_out_data.kind == K_LINE && i_out_data.line_length == '0, "line word with zero length")

endmodule

bind console_line_editor_unit cle_checker u_cle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_rx.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

/* tb/tb_console_line_editor_unit.sv */
`timescale 1ns / 100ps

module tb_console_line_editor_unit;
    import cle_pkg::*;

    localparam int LINE_CAP     = LINE_CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 385;
    localparam int LONG_HOLD    = 400;

    localparam t_res NO_WORD = '0;

    typedef struct packed {
        logic [7:0] rx;
        logic       given;
        logic       has_word;
        t_res       word;
    } t_dir_row;

    localparam int DIR_ROWS = 25;
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        '{CH_DEL,      1'b1, 1'b0, NO_WORD},
        '{CH_LF,       1'b1, 1'b0, NO_WORD},
        '{8'h20,       1'b1, 1'b1, '{K_ECHO, 8'h20, 1'b0, 6'd0}},
        '{8'h7E,       1'b1, 1'b1, '{K_ECHO, 8'h7E, 1'b0, 6'd0}},
        '{CH_DEL,      1'b1, 1'b1, '{K_ERASE, 8'h00, 1'b0, 6'd0}},
        '{CH_ETX,      1'b1, 1'b1, '{K_ABORT, 8'h00, 1'b0, 6'd0}},
        '{8'h00,       1'b1, 1'b0, NO_WORD},
        '{8'hFF,       1'b1, 1'b0, NO_WORD},
        '{CH_ESC,      1'b1, 1'b0, NO_WORD},
        '{8'h41,       1'b0, 1'b0, NO_WORD},
        '{CH_ESC,      1'b1, 1'b0, NO_WORD},
        '{CH_LBRACKET, 1'b1, 1'b0, NO_WORD},
        '{8'h31,       1'b0, 1'b0, NO_WORD},
        '{CH_LF,       1'b0, 1'b0, NO_WORD},
        '{CH_DEL,      1'b0, 1'b0, NO_WORD},
        '{CH_ETX,      1'b0, 1'b0, NO_WORD},
        '{8'h3F,       1'b0, 1'b0, NO_WORD},
        '{8'h1F,       1'b0, 1'b0, NO_WORD},
        '{8'h62,       1'b0, 1'b0, NO_WORD},
        '{CH_ESC,      1'b0, 1'b0, NO_WORD},
        '{CH_LBRACKET, 1'b0, 1'b0, NO_WORD},
        '{CH_ESC,      1'b0, 1'b0, NO_WORD},
        '{CH_LBRACKET, 1'b0, 1'b0, NO_WORD},
        '{8'h40,       1'b0, 1'b0, NO_WORD},
        '{8'h7E,       1'b0, 1'b0, NO_WORD}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    cle_stream_if #(.T(t_rx))  rx_if ();
    cle_stream_if #(.T(t_res)) res_if ();

    console_line_editor_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    always #4 i_clk = ~i_clk;

    // editor shadow state
    logic [7:0] line_mem [0:LINE_CAP-1];
    logic [5:0] line_len = '0;
    logic [1:0] esc_st   = '0;

    t_res step_words [$];
    t_res expected_words [$];

    int   err_cnt    = 0;
    int   items_done = 0;
    logic no_idle    = 1'b0;
    logic hold_go    = 1'b0;
    logic rx_hold    = 1'b0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
        err_cnt++;
    endtask

    function automatic void editor_step(input logic [7:0] c);
        t_res w;
        int   n;
        step_words.delete();
        w = NO_WORD;
        if (c == CH_DEL) begin
            if (line_len != 0) begin
                line_len--;
                w.kind = K_ERASE;
                step_words.push_back(w);
            end
            return;
        end
        if (c == CH_LF) begin
            n = line_len;
            for (int i = 0; i < n; i++) begin
                w.kind        = K_LINE;
                w.byte_value  = line_mem[i];
                w.last        = (i == n - 1);
                w.line_length = line_len;
                step_words.push_back(w);
            end
            line_len = '0;
            return;
        end
        if (c == CH_ETX) begin
            w.kind = K_ABORT;
            step_words.push_back(w);
            return;
        end
        if (c == CH_ESC) begin
            esc_st = 2'd1;
            return;
        end
        if (esc_st == 2'd1) begin
            if (c == CH_LBRACKET) begin
                esc_st = 2'd2;
                return;
            end
            esc_st = 2'd0;
        end else if (esc_st == 2'd2) begin
            if (c >= CSI_MIN && c <= CSI_MAX) begin
                if (c >= CSI_FINAL_MIN)
                    esc_st = 2'd0;
                return;
            end
            esc_st = 2'd0;
        end else begin
            esc_st = 2'd0;
        end
        if (c >= PRINT_MIN && c <= PRINT_MAX && line_len < LINE_CAP - 1) begin
            line_mem[line_len] = c;
            line_len++;
            w.kind       = K_ECHO;
            w.byte_value = c;
            step_words.push_back(w);
        end
    endfunction

    task automatic check_word(input t_res got);
        t_res want;
        if (expected_words.size() == 0) begin
            report_mismatch("unexpected word, byte_value", got.byte_value, 0);
            return;
        end
        want = expected_words.pop_front();
        if (got.kind != want.kind)
            report_mismatch("kind", got.kind, want.kind);
        if (got.byte_value != want.byte_value)
            report_mismatch("byte_value", got.byte_value, want.byte_value);
        if (got.last != want.last)
            report_mismatch("last", got.last, want.last);
        if (got.line_length != want.line_length)
            report_mismatch("line_length", got.line_length, want.line_length);
    endtask

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic send_byte(input logic [7:0] c, input logic given,
                             input logic has_word, input t_res word);
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.data  <= t_rx'(c);
        do @(posedge i_clk); while (!rx_if.ready);
        editor_step(c);
        if (given) begin
            if (has_word)
                expected_words.push_back(word);
        end else begin
            foreach (step_words[i])
                expected_words.push_back(step_words[i]);
        end
        items_done++;
    endtask

    task automatic send_plain(input logic [7:0] c);
        send_byte(c, 1'b0, 1'b0, NO_WORD);
    endtask

    function automatic logic [7:0] rand_print();
        return 8'($urandom_range(PRINT_MIN, PRINT_MAX));
    endfunction

    // result side: random ready bursts, long hold on request
    initial begin
        int stall_left;
        logic ready_nx;
        stall_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready)
                check_word(res_if.data);
            if (rx_hold) begin
                ready_nx = 1'b0;
            end else if (stall_left > 0) begin
                ready_nx = 1'b0;
                stall_left--;
            end else begin
                ready_nx = 1'b1;
                if (!no_idle && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 19);
            end
            res_if.ready <= ready_nx;
        end
    end

    initial begin
        do @(posedge i_clk); while (!hold_go);
        rx_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #20_000_000;
        $display("[console_line_editor_unit] ERROR");
        $finish;
    end

    initial begin
        int   seq;
        int   n;
        int   waited;
        logic first_seq;
        logic paused;
        rx_if.valid <= 1'b0;
        rx_if.data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_byte(DIR_TAB[r].rx, DIR_TAB[r].given, DIR_TAB[r].has_word,
                      DIR_TAB[r].word);

        items_done = 0;
        first_seq  = 1'b1;
        paused     = 1'b0;
        while (items_done < RANDOM_ITEMS) begin
            if (items_done >= 120 && !hold_go)
                hold_go <= 1'b1;
            if (items_done >= 250 && !paused) begin
                paused = 1'b1;
                rx_if.valid <= 1'b0;
                do @(posedge i_clk); while (expected_words.size() != 0);
            end
            if (items_done >= RANDOM_ITEMS - 60)
                no_idle = 1'b1;
            seq = first_seq ? 73 : $urandom_range(0, 99);
            first_seq = 1'b0;
            if (seq < 45) begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    send_plain(($urandom_range(0, 7) == 0) ? CH_DEL : rand_print());
                send_plain(CH_LF);
            end else if (seq < 60) begin
                send_plain(CH_ESC);
                send_plain(CH_LBRACKET);
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++)
                    send_plain(8'($urandom_range(CSI_MIN, CSI_FINAL_MIN - 1)));
                if ($urandom_range(0, 4) == 0)
                    send_plain(8'($urandom_range(0, 255)));
                else
                    send_plain(8'($urandom_range(CSI_FINAL_MIN, CSI_MAX)));
            end else if (seq < 68) begin
                send_plain(CH_ESC);
                send_plain(8'($urandom_range(0, 255)));
            end else if (seq < 73) begin
                send_plain(CH_ETX);
            end else if (seq < 75) begin
                // fill the line to capacity or beyond, then read the full line back
                n = $urandom_range(LINE_CAP - 1, LINE_CAP + 4);
                for (int i = 0; i < n; i++)
                    send_plain(rand_print());
                send_plain(CH_LF);
            end else begin
                send_plain(8'($urandom_range(0, 255)));
            end
        end

        rx_if.valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (expected_words.size() != 0 && waited < 200_000);
        repeat (20) @(posedge i_clk);
        if (expected_words.size() != 0)
            report_mismatch("words never returned", 0, expected_words.size());
        if (err_cnt == 0)
            $display("[console_line_editor_unit] OK");
        else
            $display("[console_line_editor_unit] ERROR");
        $finish;
    end

endmodule
